// ----- rtl/core/lz77_factor_decoder_defines.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef LZ77_FACTOR_DECODER_DEFINES_SVH
`define LZ77_FACTOR_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LZFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("lzfd assertion failed");

// Next-cycle implication, disabled while in reset.
`define LZFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lzfd assertion failed");

`endif

// ----- rtl/core/lzfd_pkg.sv -----
`default_nettype none

package lzfd_pkg;

	localparam int unsigned WINDOW = 4096;
	localparam int unsigned MAX_LEN = 64;
	localparam int unsigned ADDR_W = $clog2(WINDOW);

	localparam int unsigned LEN_W = 7;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W = 32;

	localparam logic [POS_W-1:0] WINDOW_SPAN = POS_W'(WINDOW);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} lzfd_state_t;

	typedef enum logic [1:0] {
		KIND_LIT,
		KIND_COPY,
		KIND_BAD
	} lzfd_kind_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} hist_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/lzfd_history.sv -----
`default_nettype none

module lzfd_history (
	input  wire                          clk,
	input  wire lzfd_pkg::hist_req_t     req,
	output logic [lzfd_pkg::BYTE_W-1:0]  rdata
);
	import lzfd_pkg::*;

	logic [BYTE_W-1:0] mem [WINDOW];
	logic [BYTE_W-1:0] rdata_q;

	// forward the byte being written when the copy reads it back at once
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			if (req.we && (req.waddr == req.raddr)) begin
				rdata_q <= req.wdata;
			end else begin
				rdata_q <= mem[req.raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/lz77_factor_decoder.sv -----
// channel   | signals                         | tdata / tuser / tlast
// ----------+---------------------------------+--------------------------------------------
// s (in)    | s_tvalid s_tready s_tdata       | [6:0] copy_length [14:7] literal_byte
//           |                                 | [46:15] source_position [47] zero
// m (out)   | m_tvalid m_tready m_tdata       | [7:0] out_byte, tlast last_of_factor,
//           | m_tlast m_tuser                 | tuser bad_reference
//
// A factor is taken in one cycle and checked in the next. A literal or a bad
// reference then gives its one beat, and a zero literal gives none; a good reference gives one
// beat per cycle from the history RAM while m_tready does not stall the output.
// The single history RAM port pair sets the pace: one read and one write a cycle.
// Reset clears the output count and the output valid flag; the history RAM is not cleared.
// A stalled output beat holds the copy; s_tready stays low until the factor is done.
`default_nettype none

`include "lz77_factor_decoder_defines.svh"

module lz77_factor_decoder (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// [6:0] copy_length, [14:7] literal_byte, [46:15] source_position, [47] zero
	input  wire  [lzfd_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// [7:0] out_byte
	output logic [lzfd_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	// [0] bad_reference
	output logic                            m_tuser
);
	import lzfd_pkg::*;

	lzfd_state_t       state_q, state_d;
	lzfd_kind_t        kind_q, kind_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] lit_q;
	logic [POS_W-1:0]  src_q;
	logic [POS_W-1:0]  count_q;
	logic [ADDR_W-1:0] rd_pos_q, rd_pos_d;
	logic              m_tvalid_q, m_tvalid_d;
	logic [BYTE_W-1:0] m_byte_q;
	logic              m_last_q;
	logic              m_bad_q;

	logic              accept;
	logic              out_free;
	logic              load;
	logic [POS_W:0]    diff;
	logic              bad_ref;
	logic [BYTE_W-1:0] hist_rdata;
	logic [BYTE_W-1:0] beat_byte;
	logic              beat_last;
	hist_req_t         hist_req;

	lzfd_history u_history (
		.clk   (clk),
		.req   (hist_req),
		.rdata (hist_rdata)
	);

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign diff     = {1'b0, count_q} - {1'b0, src_q};
	assign bad_ref  = (len_q > LEN_LIMIT) || diff[POS_W] || (diff[POS_W-1:0] == '0)
		|| (diff[POS_W-1:0] > WINDOW_SPAN);

	always_comb begin
		state_d        = state_q;
		kind_d         = kind_q;
		len_d          = len_q;
		rd_pos_d       = rd_pos_q;
		load           = 1'b0;
		s_tready       = 1'b0;
		beat_byte      = '0;
		beat_last      = 1'b1;
		hist_req.we    = 1'b0;
		hist_req.waddr = count_q[ADDR_W-1:0];
		hist_req.wdata = '0;
		hist_req.re    = 1'b0;
		hist_req.raddr = rd_pos_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					len_d   = s_tdata[6:0];
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (len_q == '0) begin
					kind_d  = KIND_LIT;
					state_d = (lit_q == '0) ? ST_IDLE : ST_EMIT;
				end else if (bad_ref) begin
					kind_d  = KIND_BAD;
					state_d = ST_EMIT;
				end else begin
					kind_d         = KIND_COPY;
					hist_req.re    = 1'b1;
					hist_req.raddr = src_q[ADDR_W-1:0];
					rd_pos_d       = src_q[ADDR_W-1:0] + ADDR_W'(1);
					state_d        = ST_EMIT;
				end
			end
			ST_EMIT: begin
				unique case (kind_q)
					KIND_LIT: begin
						beat_byte = lit_q;
					end
					KIND_COPY: begin
						beat_byte = hist_rdata;
						beat_last = (len_q == LEN_ONE);
					end
					default: begin
						beat_byte = '0;
					end
				endcase
				if (out_free) begin
					load           = 1'b1;
					hist_req.we    = (kind_q != KIND_BAD);
					hist_req.wdata = beat_byte;
					if (beat_last) begin
						state_d = ST_IDLE;
					end else begin
						hist_req.re = 1'b1;
						rd_pos_d    = rd_pos_q + ADDR_W'(1);
						len_d       = len_q - LEN_ONE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		m_tvalid_d = load || (m_tvalid_q && !m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			m_tvalid_q <= m_tvalid_d;
			if (hist_req.we) begin
				count_q <= count_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		len_q    <= len_d;
		rd_pos_q <= rd_pos_d;
		if (accept) begin
			lit_q <= s_tdata[14:7];
			src_q <= s_tdata[46:15];
		end
		if (load) begin
			m_byte_q <= beat_byte;
			m_last_q <= beat_last;
			m_bad_q  <= (kind_q == KIND_BAD);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_byte_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_bad_q;

	`LZFD_ASSERT_NOW(a_bad_is_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`LZFD_ASSERT_NOW(a_bad_is_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	`LZFD_ASSERT_NEXT(a_busy_after_take, clk, arst_n, accept, !s_tready)
	`LZFD_ASSERT_NEXT(a_count_step, clk, arst_n, hist_req.we,
		count_q == $past(count_q) + POS_W'(1))

endmodule

`default_nettype wire

// ----- tb/lz77_factor_decoder_tb.sv -----
`default_nettype none

module lz77_factor_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned ADDR_W = lzfd_pkg::ADDR_W;
	localparam int unsigned SPAN = lzfd_pkg::WINDOW;

	typedef struct packed {
		logic [lzfd_pkg::POS_W-1:0]  source_position;
		logic [lzfd_pkg::BYTE_W-1:0] literal_byte;
		logic [lzfd_pkg::LEN_W-1:0]  copy_length;
	} factor_t;

	typedef struct packed {
		logic [lzfd_pkg::BYTE_W-1:0] out_byte;
		logic                        last_of_factor;
		logic                        bad_reference;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [lzfd_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lzfd_pkg::M_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	factor_t factor_queue[$];
	factor_t factor_on_bus;
	beat_t expected_beats[$];

	logic [lzfd_pkg::BYTE_W-1:0] history_copy [0:SPAN-1];
	logic [lzfd_pkg::POS_W-1:0] decoded_count = '0;
	logic [lzfd_pkg::POS_W-1:0] planned_count = '0;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_kick = 1'b0;
	int unsigned hold_left;
	int mismatch_count = 0;

	lz77_factor_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #4 clk = ~clk;

	function automatic void decode_factor(input factor_t f);
		logic [lzfd_pkg::POS_W-1:0] gap;
		logic [lzfd_pkg::POS_W-1:0] rd_pos;
		logic [lzfd_pkg::BYTE_W-1:0] b;
		beat_t r;
		gap = decoded_count - f.source_position;
		if (f.copy_length == '0) begin
			if (f.literal_byte != '0) begin
				history_copy[decoded_count[ADDR_W-1:0]] = f.literal_byte;
				decoded_count = decoded_count + 1;
				r.out_byte = f.literal_byte;
				r.last_of_factor = 1'b1;
				r.bad_reference = 1'b0;
				expected_beats.push_back(r);
			end
		end else if (f.copy_length > lzfd_pkg::LEN_LIMIT || f.source_position >= decoded_count
				|| gap > lzfd_pkg::WINDOW_SPAN) begin
			r.out_byte = '0;
			r.last_of_factor = 1'b1;
			r.bad_reference = 1'b1;
			expected_beats.push_back(r);
		end else begin
			for (int i = 0; i < int'(f.copy_length); i++) begin
				rd_pos = f.source_position + lzfd_pkg::POS_W'(i);
				b = history_copy[rd_pos[ADDR_W-1:0]];
				history_copy[decoded_count[ADDR_W-1:0]] = b;
				decoded_count = decoded_count + 1;
				r.out_byte = b;
				r.last_of_factor = (i + 1 == int'(f.copy_length));
				r.bad_reference = 1'b0;
				expected_beats.push_back(r);
			end
		end
	endfunction

	// Driver: hold the beat until taken, then advance to the next factor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				decode_factor(factor_on_bus);
			if (factor_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				factor_on_bus = factor_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, factor_on_bus};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_kick)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= (hold_left == 0) && !hold_kick && ($urandom_range(99) >= rx_stall_pct);
	end

	// Monitor: compare each output beat with the oldest expectation.
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: out_byte %0h last %0b bad %0b", m_tdata, m_tlast, m_tuser);
				mismatch_count++;
			end else begin
				want = expected_beats.pop_front();
				if (m_tdata !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== want.last_of_factor) begin
					$error("last_of_factor: expected %0b, got %0b", want.last_of_factor, m_tlast);
					mismatch_count++;
				end
				if (m_tuser !== want.bad_reference) begin
					$error("bad_reference: expected %0b, got %0b", want.bad_reference, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	function automatic void add_literal(input logic [7:0] b);
		factor_t f;
		f.copy_length = '0;
		f.literal_byte = b;
		f.source_position = $urandom;
		factor_queue.push_back(f);
		if (b != 8'h00)
			planned_count = planned_count + 1;
	endfunction

	function automatic void add_copy(input int unsigned gap, input int unsigned len);
		factor_t f;
		f.copy_length = lzfd_pkg::LEN_W'(len);
		f.literal_byte = 8'($urandom_range(255));
		f.source_position = planned_count - gap;
		factor_queue.push_back(f);
		planned_count = planned_count + len;
	endfunction

	function automatic void add_bad(input int unsigned len, input logic [31:0] src);
		factor_t f;
		f.copy_length = lzfd_pkg::LEN_W'(len);
		f.literal_byte = 8'($urandom_range(255));
		f.source_position = src;
		factor_queue.push_back(f);
	endfunction

	function automatic int unsigned pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return $urandom_range(1, 8);
		else if (r < 80)
			return $urandom_range(9, 32);
		else
			return $urandom_range(33, lzfd_pkg::MAX_LEN);
	endfunction

	function automatic void add_random_factor();
		int r;
		int k;
		int unsigned len;
		int unsigned reach;
		int unsigned far;
		logic [31:0] src;
		r = $urandom_range(99);
		reach = (planned_count < SPAN) ? planned_count : SPAN;
		if (r < 22 || (r < 85 && planned_count == 0)) begin
			add_literal(8'($urandom_range(1, 255)));
		end else if (r < 25) begin
			add_literal(8'h00);
		end else if (r < 85) begin
			len = pick_len();
			k = $urandom_range(99);
			if (k < 40)
				add_copy($urandom_range(1, (len < reach) ? len : reach), len);
			else if (k < 80)
				add_copy($urandom_range(1, reach), len);
			else if (k < 90)
				add_copy(reach, len);
			else
				add_copy(1, len);
		end else begin
			k = $urandom_range(3);
			if (k == 0 && planned_count != 0) begin
				add_bad($urandom_range(lzfd_pkg::MAX_LEN + 1, 127),
					planned_count - $urandom_range(1, reach));
			end else if (k == 1 || planned_count <= SPAN + 1) begin
				add_bad($urandom_range(1, lzfd_pkg::MAX_LEN), planned_count + $urandom_range(0, 2));
			end else if (k == 2) begin
				src = $urandom;
				if (src < planned_count)
					src = planned_count;
				add_bad($urandom_range(1, 127), src);
			end else begin
				far = planned_count - SPAN - 1;
				add_bad($urandom_range(1, lzfd_pkg::MAX_LEN),
					far - $urandom_range(0, (far < 1000) ? far : 1000));
			end
		end
	endfunction

	task automatic run_phase(input int n, input int tx_pct, input int rx_pct, input bit squeeze);
		int done;
		while (factor_queue.size() != 0)
			@(posedge clk);
		@(negedge clk);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		done = 0;
		while (done < n) begin
			add_random_factor();
			if (factor_queue[$].copy_length != '0 || factor_queue[$].literal_byte != '0)
				done++;
		end
		if (squeeze) begin
			hold_kick = 1'b1;
			@(negedge clk);
			hold_kick = 1'b0;
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_literal(8'h01);
		add_literal(8'hFF);
		add_literal(8'h00);
		add_literal(8'h80);
		add_literal(8'h7F);
		add_bad(1, planned_count);
		add_bad(1, 32'hFFFF_FFFF);
		add_copy(4, 1);
		add_copy(1, lzfd_pkg::MAX_LEN);
		add_copy(3, 7);
		add_bad(lzfd_pkg::MAX_LEN + 1, 0);
		add_bad(127, 0);
		add_literal(8'h55);
		add_literal(8'hAA);
		add_copy(planned_count, lzfd_pkg::MAX_LEN);
		add_copy(2, 2);
		add_bad(lzfd_pkg::MAX_LEN, 32'h8000_0000);
		add_copy(planned_count, 1);
		add_literal(8'h00);
		add_copy(1, 1);

		run_phase(110, 0, 0, 1'b0);
		run_phase(110, 71, 0, 1'b0);
		run_phase(110, 0, 71, 1'b0);
		run_phase(110, 6, 6, 1'b1);

		while (factor_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_beats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lzfd_pkg.sv
rtl/core/lzfd_history.sv
rtl/core/lz77_factor_decoder.sv
tb/lz77_factor_decoder_tb.sv
